@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the crossbar path evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/cpe_pkg.sv @@
// Types, constants and helper functions of the crossbar path evaluator.
package cpe_pkg;

	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;
	localparam int DEF_MAX_VARS = 16;

	localparam int CELL_W   = 6;
	localparam int VAR_W    = 5;
	localparam int ASG_W    = 16;
	localparam int ROW_IN_W = 5;
	localparam int COL_IN_W = 5;
	localparam int CFG_W    = 6;
	localparam int IDX_W    = 2;
	localparam int CNT_W    = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

	localparam logic [IDX_W-1:0] REG_ROWS_USED = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_COLS_USED = IDX_W'(1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic load_read;
		logic load_write;
		logic sweep;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic done;
		logic out_free;
	} sts_t;

	// A variable beyond the supported range reads as false.
	function automatic logic cell_conducts(input logic [CELL_W-1:0] cell_word,
		input logic [ASG_W-1:0] asg, input int max_vars);
		logic [VAR_W-1:0] var_id;
		logic             pol;
		logic             value;
		var_id = cell_word[CELL_W-1:1];
		pol    = cell_word[0];
		if (var_id == '0) begin
			return pol;
		end
		if (int'(var_id) > max_vars || int'(var_id) > ASG_W) begin
			value = 1'b0;
		end else begin
			value = asg[4'(var_id - VAR_W'(1))];
		end
		return pol ? value : !value;
	endfunction

endpackage

@@ hw/rtl/cpe_ctrl.sv @@
// Controller state machine of the crossbar path evaluator.
`include "assert_macros.svh"

module cpe_ctrl
	import cpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic kind,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = (kind == KIND_EVAL) ? ST_EVAL : ST_LOAD_RD;
				end
			end
			ST_LOAD_RD: begin
				cmd.load_read = 1'b1;
				state_nx      = ST_LOAD_WR;
			end
			ST_LOAD_WR: begin
				cmd.load_write = 1'b1;
				state_nx       = ST_IDLE;
			end
			ST_EVAL: begin
				cmd.sweep = 1'b1;
				if (sts.done) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_nx        = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEVER(a_result_overrun, clk, arst_n, cmd.result_load && !sts.out_free)
	`ASSERT_PROP(a_clear_once, clk, arst_n, (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
	`ASSERT_NEVER(a_accept_while_busy, clk, arst_n, cmd.capture && (cmd.sweep || cmd.clear))

endmodule

@@ hw/rtl/cpe_dp.sv @@
// Datapath of the crossbar path evaluator: cell memory, reach masks and result register.
`include "assert_macros.svh"

module cpe_dp
	import cpe_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_VARS = DEF_MAX_VARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [CFG_W-1:0]    wr_data,
	input  logic [ROW_IN_W-1:0] row_index,
	input  logic [COL_IN_W-1:0] col_index,
	input  logic [VAR_W-1:0]    var_number,
	input  logic                polarity,
	input  logic [ASG_W-1:0]    assignment,
	input  logic                out_ready,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                out_valid,
	output logic                connected
);

	localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROW_BITS = MAX_COLS * CELL_W;

	logic [ROW_BITS-1:0] cell_mem [MAX_ROWS];

	logic [CFG_W-1:0]    rows_used_q;
	logic [CFG_W-1:0]    cols_used_q;
	logic [ROW_IN_W-1:0] row_q;
	logic [COL_IN_W-1:0] col_q;
	logic [VAR_W-1:0]    var_q;
	logic                pol_q;
	logic [ASG_W-1:0]    asg_q;

	logic [RW-1:0]       rd_row_q;
	logic [ROW_BITS-1:0] rd_data_s1;
	logic                proc_s1;
	logic [RW-1:0]       proc_row_s1;
	logic                proc_last_s1;

	logic [MAX_ROWS-1:0] rmask_q;
	logic [MAX_COLS-1:0] cmask_q;
	logic                changed_q;
	logic                hit_q;
	logic                out_valid_q;
	logic                connected_q;

	logic [CNT_W-1:0]    nr;
	logic [CNT_W-1:0]    nc;
	logic [RW-1:0]       src_row;
	logic                row_last;
	logic                row_ok;
	logic                col_ok;
	logic [RW-1:0]       load_addr;
	logic [RW-1:0]       rd_addr;
	logic [RW-1:0]       wr_addr;
	logic                mem_we;
	logic [ROW_BITS-1:0] merged;
	logic [ROW_BITS-1:0] wr_word;
	logic [MAX_COLS-1:0] cond;
	logic                active;
	logic                row_reached;
	logic                reach;
	logic [MAX_COLS-1:0] cmask_nx;
	logic                row_change;
	logic                any_change;
	logic                pass_end;

	// Counts of zero are taken as one and counts beyond the array as its size.
	always_comb begin
		nr = CNT_W'(rows_used_q);
		nc = CNT_W'(cols_used_q);
		if (nr == '0) begin
			nr = CNT_W'(1);
		end else if (nr > CNT_W'(MAX_ROWS)) begin
			nr = CNT_W'(MAX_ROWS);
		end
		if (nc == '0) begin
			nc = CNT_W'(1);
		end else if (nc > CNT_W'(MAX_COLS)) begin
			nc = CNT_W'(MAX_COLS);
		end
	end

	assign src_row   = RW'(nr - CNT_W'(1));
	assign row_last  = (rd_row_q == src_row);
	assign row_ok    = (CNT_W'(row_q) < CNT_W'(MAX_ROWS));
	assign col_ok    = (CNT_W'(col_q) < CNT_W'(MAX_COLS));
	assign load_addr = RW'(row_q);

	always_comb begin
		merged = rd_data_s1;
		for (int c = 0; c < MAX_COLS; c++) begin
			if (CNT_W'(col_q) == CNT_W'(c)) begin
				merged[c*CELL_W +: CELL_W] = {var_q, pol_q};
			end
		end
	end

	assign rd_addr = cmd.load_read ? load_addr : rd_row_q;
	assign wr_addr = cmd.clear ? rd_row_q : load_addr;
	assign wr_word = cmd.clear ? '0 : merged;
	assign mem_we  = cmd.clear || (cmd.load_write && row_ok && col_ok);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[wr_addr] <= wr_word;
		end
		rd_data_s1 <= cell_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= CFG_RESET;
			cols_used_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROWS_USED: rows_used_q <= wr_data;
				REG_COLS_USED: cols_used_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= row_index;
			col_q <= col_index;
			var_q <= var_number;
			pol_q <= polarity;
			asg_q <= assignment;
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			cond[c] = (CNT_W'(c) < nc)
				&& cell_conducts(rd_data_s1[c*CELL_W +: CELL_W], asg_q, MAX_VARS);
		end
	end

	assign active      = proc_s1 && cmd.sweep;
	assign row_reached = rmask_q[proc_row_s1];
	assign reach       = row_reached || |(cond & cmask_q);
	assign cmask_nx    = reach ? (cmask_q | cond) : cmask_q;
	assign row_change  = reach && (!row_reached || (cmask_nx != cmask_q));
	assign any_change  = changed_q || row_change;
	assign pass_end    = active && proc_last_s1;

	assign sts.clear_last = (rd_row_q == RW'(MAX_ROWS - 1));
	assign sts.done       = pass_end && !any_change;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_row_q <= '0;
			proc_s1  <= 1'b0;
		end else begin
			proc_s1 <= cmd.sweep;
			if (cmd.capture) begin
				rd_row_q <= '0;
			end else if (cmd.clear) begin
				rd_row_q <= rd_row_q + RW'(1);
			end else if (cmd.sweep) begin
				rd_row_q <= row_last ? '0 : rd_row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		proc_row_s1  <= rd_row_q;
		proc_last_s1 <= row_last;
	end

	// Passes over the used rows repeat until one pass reaches nothing new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmask_q   <= '0;
			cmask_q   <= '0;
			changed_q <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.capture) begin
			rmask_q   <= MAX_ROWS'(1) << src_row;
			cmask_q   <= '0;
			changed_q <= 1'b0;
			hit_q     <= 1'b0;
		end else if (active) begin
			if (reach) begin
				rmask_q[proc_row_s1] <= 1'b1;
			end
			cmask_q   <= cmask_nx;
			changed_q <= pass_end ? 1'b0 : any_change;
			if (proc_row_s1 == '0) begin
				hit_q <= |(cond & cmask_nx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			connected_q <= hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign connected = connected_q;

	`ASSERT_PROP(a_rows_grow, clk, arst_n, cmd.sweep |=> ((rmask_q & $past(rmask_q)) == $past(rmask_q)))
	`ASSERT_PROP(a_cols_grow, clk, arst_n, cmd.sweep |=> ((cmask_q & $past(cmask_q)) == $past(cmask_q)))
	`ASSERT_PROP(a_src_reached, clk, arst_n, cmd.sweep |-> rmask_q[src_row])

endmodule

@@ hw/rtl/crossbar_path_evaluator.sv @@
// Top level of the crossbar path evaluator.
//
// Input words arrive on in_valid/in_ready. A load word (kind low) writes one
// cell of the crossbar and gives no result; it reads and rewrites its row.
// An evaluate word (kind high) carries an assignment and gives one result
// word on out_valid/out_ready, whose connected bit tells whether the last
// used row reaches row 0 through conducting cells.
// An evaluation sweeps the used rows, one memory row per cycle, and repeats
// the sweep until a full pass reaches no new row or column. The number of
// passes is at least 1 and at most rows + 1, and the cell memory has a
// single read port.
// After reset the cell memory is cleared one row per cycle, all MAX_ROWS rows,
// during which in_ready stays low; configuration writes are taken.
// The result sits in an output register, so a new word is accepted while it
// waits; if the receiver stalls, a following evaluation holds in its last
// state until the register is free. rows_used and cols_used are written
// through wr_en, wr_index and wr_data; the user must do so only while the
// block is idle, which the block does not enforce. Both reset to 32.
module crossbar_path_evaluator
	import cpe_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_VARS = DEF_MAX_VARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [CFG_W-1:0]    wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [ROW_IN_W-1:0] row_index,
	input  logic [COL_IN_W-1:0] col_index,
	input  logic [VAR_W-1:0]    var_number,
	input  logic                polarity,
	input  logic [ASG_W-1:0]    assignment,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                connected
);

	cmd_t cmd;
	sts_t sts;

	cpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cpe_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_VARS (MAX_VARS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.row_index  (row_index),
		.col_index  (col_index),
		.var_number (var_number),
		.polarity   (polarity),
		.assignment (assignment),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.connected  (connected)
	);

endmodule
